// File: rtl/core/tlc_pkg.sv
// ----------------------------------------------------------------------------
// Traffic light controller package
// Shared types, codes and reset constants for the two-way traffic light
// controller.
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam int unsigned CountW = 8;
  localparam int unsigned CfgW   = 8;

  localparam logic [CountW-1:0] ClearTimeRst    = 8'd80;
  localparam logic [CountW-1:0] ApproachTimeRst = 8'd20;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ON    = 2'd1,
    OP_OFF   = 2'd2,
    OP_FORCE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_OFF  = 3'd0,
    PH_ACLR = 3'd1,
    PH_ATOB = 3'd2,
    PH_BCLR = 3'd3,
    PH_BTOA = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    LT_OFF   = 2'd0,
    LT_STOP  = 2'd1,
    LT_APPR  = 2'd2,
    LT_CLEAR = 2'd3
  } light_e;

  typedef enum logic {
    CFG_CLEAR_TIME    = 1'b0,
    CFG_APPROACH_TIME = 1'b1
  } cfg_idx_e;

  localparam logic STREET_A = 1'b0;

  typedef struct packed {
    logic [1:0] operation;
    logic       street;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] light_a;
    logic [1:0] light_b;
  } out_beat_t;

  typedef struct packed {
    logic [CountW-1:0] clear_time;
    logic [CountW-1:0] approach_time;
  } cfg_t;

  typedef struct packed {
    phase_e            phase;
    logic [CountW-1:0] countdown;
    light_e            lamp_a;
    light_e            lamp_b;
  } tlc_state_t;

endpackage

// File: rtl/core/tlc_cfg.sv
// ----------------------------------------------------------------------------
// Traffic light controller configuration registers
// Holds the clear and approach countdown times written through the plain
// write port.
// ----------------------------------------------------------------------------
module tlc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [tlc_pkg::CfgW-1:0]      cfg_data_i,
  output tlc_pkg::cfg_t                 cfg_o
);

  tlc_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (tlc_pkg::cfg_idx_e'(cfg_idx_i))
        tlc_pkg::CFG_CLEAR_TIME:    cfg_d.clear_time    = cfg_data_i[tlc_pkg::CountW-1:0];
        tlc_pkg::CFG_APPROACH_TIME: cfg_d.approach_time = cfg_data_i[tlc_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clear_time    <= tlc_pkg::ClearTimeRst;
      cfg_q.approach_time <= tlc_pkg::ApproachTimeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/tlc_step.sv
// ----------------------------------------------------------------------------
// Traffic light controller step logic
// Computes the controller state that one operation leaves behind.
// ----------------------------------------------------------------------------
module tlc_step (
  input  tlc_pkg::in_beat_t   beat_i,
  input  tlc_pkg::cfg_t       cfg_i,
  input  tlc_pkg::tlc_state_t state_i,
  output tlc_pkg::tlc_state_t state_o
);

  tlc_pkg::op_e                 op;
  tlc_pkg::phase_e              phase_d;
  logic [tlc_pkg::CountW-1:0]   count_d;
  tlc_pkg::light_e              lamp_a_d;
  tlc_pkg::light_e              lamp_b_d;
  logic                         expired;

  assign op      = tlc_pkg::op_e'(beat_i.operation);
  assign expired = (state_i.phase != tlc_pkg::PH_OFF) && (state_i.countdown == '0);

  // Phase and countdown.
  always_comb begin
    phase_d = state_i.phase;
    count_d = state_i.countdown;
    unique case (op)
      tlc_pkg::OP_TICK: begin
        if (state_i.phase != tlc_pkg::PH_OFF) begin
          if (state_i.countdown != '0) begin
            count_d = state_i.countdown - 1'b1;
          end else begin
            unique case (state_i.phase)
              tlc_pkg::PH_ACLR: begin
                phase_d = tlc_pkg::PH_ATOB;
                count_d = cfg_i.clear_time;
              end
              tlc_pkg::PH_ATOB: begin
                phase_d = tlc_pkg::PH_BCLR;
                count_d = cfg_i.approach_time;
              end
              tlc_pkg::PH_BCLR: begin
                phase_d = tlc_pkg::PH_BTOA;
                count_d = cfg_i.clear_time;
              end
              tlc_pkg::PH_BTOA: begin
                phase_d = tlc_pkg::PH_ACLR;
                count_d = cfg_i.approach_time;
              end
              default: ;
            endcase
          end
        end
      end
      tlc_pkg::OP_ON: begin
        if (state_i.phase == tlc_pkg::PH_OFF) begin
          phase_d = tlc_pkg::PH_ACLR;
          count_d = '0;
        end
      end
      tlc_pkg::OP_OFF: begin
        phase_d = tlc_pkg::PH_OFF;
        count_d = '0;
      end
      tlc_pkg::OP_FORCE: begin
        if (state_i.phase != tlc_pkg::PH_OFF) begin
          if (beat_i.street == tlc_pkg::STREET_A) begin
            if (state_i.lamp_a == tlc_pkg::LT_CLEAR || state_i.lamp_a == tlc_pkg::LT_APPR) begin
              phase_d = tlc_pkg::PH_ACLR;
              count_d = '0;
            end else if (state_i.lamp_b != tlc_pkg::LT_APPR) begin
              phase_d = tlc_pkg::PH_BTOA;
              count_d = '0;
            end
          end else begin
            if (state_i.lamp_b == tlc_pkg::LT_APPR || state_i.lamp_b == tlc_pkg::LT_CLEAR) begin
              phase_d = tlc_pkg::PH_BCLR;
              count_d = '0;
            end else if (state_i.lamp_a != tlc_pkg::LT_APPR) begin
              phase_d = tlc_pkg::PH_ATOB;
              count_d = '0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Lights.
  always_comb begin
    lamp_a_d = state_i.lamp_a;
    lamp_b_d = state_i.lamp_b;
    if (op == tlc_pkg::OP_OFF) begin
      lamp_a_d = tlc_pkg::LT_OFF;
      lamp_b_d = tlc_pkg::LT_OFF;
    end else if (op == tlc_pkg::OP_TICK && expired) begin
      unique case (state_i.phase)
        tlc_pkg::PH_ACLR: begin
          lamp_a_d = tlc_pkg::LT_CLEAR;
          lamp_b_d = tlc_pkg::LT_STOP;
        end
        tlc_pkg::PH_ATOB: begin
          lamp_a_d = tlc_pkg::LT_APPR;
          lamp_b_d = tlc_pkg::LT_STOP;
        end
        tlc_pkg::PH_BCLR: begin
          lamp_a_d = tlc_pkg::LT_STOP;
          lamp_b_d = tlc_pkg::LT_CLEAR;
        end
        tlc_pkg::PH_BTOA: begin
          lamp_a_d = tlc_pkg::LT_STOP;
          lamp_b_d = tlc_pkg::LT_APPR;
        end
        default: ;
      endcase
    end
  end

  assign state_o.phase     = phase_d;
  assign state_o.countdown = count_d;
  assign state_o.lamp_a    = lamp_a_d;
  assign state_o.lamp_b    = lamp_b_d;

endmodule

// File: rtl/core/two_way_traffic_light_controller.sv
// ----------------------------------------------------------------------------
// Two-way traffic light controller
// Each accepted beat goes to the input register, its result to the output
// register. One beat per cycle unless the output stalls; the input register
// feeds the step logic, whose result lands in the output register together
// with the new state. Reset clears the pipeline, turns the controller off
// with both lights off, and sets the clear and approach times to 80 and 20.
// ----------------------------------------------------------------------------
module two_way_traffic_light_controller (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  tlc_pkg::in_beat_t        in_beat_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output tlc_pkg::out_beat_t       out_beat_o,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [tlc_pkg::CfgW-1:0] cfg_data_i
);

  tlc_pkg::cfg_t       cfg;
  tlc_pkg::tlc_state_t state_d, state_q, step_state;
  tlc_pkg::in_beat_t   s1_beat_d, s1_beat_q;
  tlc_pkg::out_beat_t  out_beat_d, out_beat_q;
  logic                s1_valid_d, s1_valid_q;
  logic                out_valid_d, out_valid_q;
  logic                s1_adv;
  logic                in_fire;

  tlc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tlc_step u_step (
    .beat_i  (s1_beat_q),
    .cfg_i   (cfg),
    .state_i (state_q),
    .state_o (step_state)
  );

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    s1_beat_d   = s1_beat_q;
    out_valid_d = out_valid_q;
    out_beat_d  = out_beat_q;
    state_d     = state_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_adv) begin
      s1_valid_d         = 1'b0;
      out_valid_d        = 1'b1;
      state_d            = step_state;
      out_beat_d.light_a = step_state.lamp_a;
      out_beat_d.light_b = step_state.lamp_b;
    end
    if (in_fire) begin
      s1_valid_d = 1'b1;
      s1_beat_d  = in_beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
      state_q.phase     <= tlc_pkg::PH_OFF;
      state_q.countdown <= '0;
      state_q.lamp_a    <= tlc_pkg::LT_OFF;
      state_q.lamp_b    <= tlc_pkg::LT_OFF;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_beat_q  <= s1_beat_d;
    out_beat_q <= out_beat_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

`ifndef NO_ASSERTIONS
  // While the controller is off, the countdown is cleared.
  a_off_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == tlc_pkg::PH_OFF |-> state_q.countdown == '0)
    else $error("countdown nonzero while off");

  // While the controller is off, both lights are off.
  a_off_lamps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == tlc_pkg::PH_OFF |->
      (state_q.lamp_a == tlc_pkg::LT_OFF && state_q.lamp_b == tlc_pkg::LT_OFF))
    else $error("lights on while controller off");

  // While street A may go, street B is stopped.
  a_no_conflict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.lamp_a == tlc_pkg::LT_CLEAR || state_q.lamp_a == tlc_pkg::LT_APPR) |->
      state_q.lamp_b == tlc_pkg::LT_STOP)
    else $error("conflicting lights");

  // A held input beat keeps its register and does not touch the state.
  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_beat_q) && $stable(state_q)))
    else $error("stalled beat lost or state changed");

  // The output register reflects the lights after each processed beat.
  a_out_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (out_valid_q && out_beat_q.light_a == state_q.lamp_a
                && out_beat_q.light_b == state_q.lamp_b))
    else $error("result does not match light state");
`endif

endmodule
